// ----- design/btpc_pkg.sv -----
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and constants
// Item payload types, status codes and register indexes of the compensation core.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int CFG_W   = 48;
	localparam int IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int DIV_BITS    = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_TEMP_CALIB   = 3'd0,
		REG_PRESS_A      = 3'd1,
		REG_PRESS_B      = 3'd2,
		REG_PRESS_C      = 3'd3,
		REG_OVERSAMPLING = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PRESS_OFF = 2'd1,
		ST_DIV_ZERO  = 2'd2
	} status_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] temperature_centi;
		logic [31:0]        pressure_pa;
		logic [1:0]         status;
	} out_item_t;

	// Item handed from the front to the divide/finish back end.
	typedef struct packed {
		logic [23:0] temp;
		logic [31:0] num;     // numerator before the unsigned divide
		logic [31:0] den;
		logic        big;     // numerator had top bit set
		logic [1:0]  status;
	} work_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
		return 32'(a * b);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] w);
		return {{16{w[15]}}, w};
	endfunction

endpackage

// ----- design/btpc_front.sv -----
// ----------------------------------------------------------------------------
// btpc_front: temperature and pressure front stages
// Pipelined compensation up to the pressure numerator and divisor.
// ----------------------------------------------------------------------------
module btpc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  btpc_pkg::in_item_t in_item,
	input  logic [47:0]        temp_calib,
	input  logic [47:0]        press_a,
	input  logic [47:0]        press_b,
	input  logic [2:0]         osr,
	output logic               out_valid,
	output btpc_pkg::work_t    out_work
);
	import btpc_pkg::*;

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5;
	logic [31:0] rt, rp;
	// stage 1
	logic        v_s1;
	logic [31:0] a_s1, b_s1, rp_s1;
	// stage 2
	logic        v_s2;
	logic [31:0] v1_s2, bb_s2, rp_s2;
	// stage 3
	logic        v_s3;
	logic [31:0] v2m_s3, v1_s3, rp_s3;
	// stage 4
	logic        v_s4;
	logic [31:0] tf_s4, rp_s4;
	// stage 5
	logic        v_s5;
	logic [31:0] tm_s5, pv1_s5, q_s5, rp_s5;
	// stage 6
	logic        v_s6;
	logic [31:0] temp_s6, x6_s6, x5_s6, x2_s6, qq_s6, rp_s6;
	// stage 7
	logic        v_s7;
	logic [31:0] temp_s7, v2_s7, v1_s7, rp_s7;
	// stage 8
	logic        v_s8;
	logic [31:0] temp_s8, den_s8, num_s8;

	logic [31:0] c_v2;

	assign t1 = {16'd0, temp_calib[47:32]};
	assign t2 = sx16(temp_calib[31:16]);
	assign t3 = sx16(temp_calib[15:0]);
	assign p1 = {16'd0, press_a[47:32]};
	assign p2 = sx16(press_a[31:16]);
	assign p3 = sx16(press_a[15:0]);
	assign p4 = sx16(press_b[47:32]);
	assign p5 = sx16(press_b[31:16]);
	assign rt = {12'd0, in_item.raw_temperature};
	assign rp = {12'd0, in_item.raw_pressure};

	assign c_v2 = asr(mul(asr(qq_s6, 11), x6_s6) + (x5_s6 << 1), 2) + (p4 << 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= asr(rt, 3) - (t1 << 1);
		b_s1   <= asr(rt, 4) - t1;
		rp_s1  <= rp;
		v1_s2  <= asr(mul(a_s1, t2), 11);
		bb_s2  <= asr(mul(b_s1, b_s1), 12);
		rp_s2  <= rp_s1;
		v2m_s3 <= asr(mul(bb_s2, t3), 14);
		v1_s3  <= v1_s2;
		rp_s3  <= rp_s2;
		tf_s4  <= v1_s3 + v2m_s3;
		rp_s4  <= rp_s3;
		tm_s5  <= mul(tf_s4, 32'd5) + 32'd128;
		pv1_s5 <= asr(tf_s4, 1) - 32'd64000;
		q_s5   <= asr(asr(tf_s4, 1) - 32'd64000, 2);
		rp_s5  <= rp_s4;
		temp_s6 <= asr(tm_s5, 8);
		qq_s6  <= mul(q_s5, q_s5);
		x6_s6  <= sx16(press_b[15:0]);
		x5_s6  <= mul(pv1_s5, p5);
		x2_s6  <= mul(p2, pv1_s5);
		rp_s6  <= rp_s5;
		temp_s7 <= temp_s6;
		v2_s7  <= c_v2;
		v1_s7  <= asr(asr(mul(p3, asr(qq_s6, 13)), 3) + asr(x2_s6, 1), 18);
		rp_s7  <= rp_s6;
		temp_s8 <= temp_s7;
		den_s8 <= asr(mul(32'd32768 + v1_s7, p1), 15);
		num_s8 <= mul((32'd1048576 - rp_s7) - asr(v2_s7, 12), 32'd3125);
	end

	always_comb begin
		out_valid       = v_s8;
		out_work.temp   = temp_s8[23:0];
		out_work.num    = (num_s8[31]) ? num_s8 : (num_s8 << 1);
		out_work.big    = num_s8[31];
		out_work.den    = den_s8;
		if (osr == 3'd0) out_work.status = ST_PRESS_OFF;
		else if (den_s8 == '0) out_work.status = ST_DIV_ZERO;
		else out_work.status = ST_OK;
	end

endmodule

// ----- design/btpc_queue.sv -----
// ----------------------------------------------------------------------------
// btpc_queue: work queue
// Short FIFO between front and back ends.
// ----------------------------------------------------------------------------
module btpc_queue #(
	parameter int Depth = btpc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  btpc_pkg::work_t push_data,
	input  logic            pop,
	output logic            not_empty,
	output btpc_pkg::work_t pop_data
);
	import btpc_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	work_t          mem [Depth];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == (AW+1)'(Depth)))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("count slip");

endmodule

// ----- design/btpc_back.sv -----
// ----------------------------------------------------------------------------
// btpc_back: divide and finish
// Array divider, one quotient bit per row, then the P7..P9 correction stages.
// ----------------------------------------------------------------------------
module btpc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  btpc_pkg::work_t     in_work,
	input  logic [47:0]         press_c,
	output logic                out_valid,
	output btpc_pkg::out_item_t out_item
);
	import btpc_pkg::*;

	localparam int N = DIV_BITS;

	logic        v_d   [N+1];
	logic [31:0] rem_d [N+1];
	logic [31:0] quo_d [N+1];
	logic [31:0] num_d [N+1];
	work_t       w_d   [N+1];

	assign v_d[0]   = in_valid;
	assign rem_d[0] = '0;
	assign quo_d[0] = '0;
	assign num_d[0] = in_work.num;
	assign w_d[0]   = in_work;

	for (genvar i = 0; i < N; i++) begin : g_row
		logic [32:0] r;
		logic [32:0] d;
		assign r = {rem_d[i], num_d[i][31]};
		assign d = r - {1'b0, w_d[i].den};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else         v_d[i+1] <= v_d[i];
		end
		always_ff @(posedge clk) begin
			rem_d[i+1] <= d[32] ? r[31:0] : d[31:0];
			quo_d[i+1] <= {quo_d[i][30:0], ~d[32]};
			num_d[i+1] <= {num_d[i][30:0], 1'b0};
			w_d[i+1]   <= w_d[i];
		end
	end

	logic        v_f1, v_f2, v_f3;
	logic [31:0] pq, p_f1, p_f2, p_f3, ps_f1, p8_f1, w1_f2, w2_f2, pf;
	work_t       w_f1, w_f2, w_f3;

	// Double the quotient back when the numerator was too large to pre-shift
	assign pq = w_d[N].big ? (quo_d[N] << 1) : quo_d[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0; v_f2 <= 1'b0; v_f3 <= 1'b0;
		end else begin
			v_f1 <= v_d[N]; v_f2 <= v_f1; v_f3 <= v_f2;
		end
	end

	always_ff @(posedge clk) begin
		p_f1  <= pq;
		w_f1  <= w_d[N];
		ps_f1 <= mul(pq >> 3, pq >> 3) >> 13;
		p8_f1 <= mul(pq >> 2, sx16(press_c[31:16]));
		p_f2  <= p_f1;
		w_f2  <= w_f1;
		w1_f2 <= asr(mul(sx16(press_c[15:0]), ps_f1), 12);
		w2_f2 <= asr(p8_f1, 13);
		p_f3  <= p_f2 + asr(w1_f2 + w2_f2 + sx16(press_c[47:32]), 4);
		w_f3  <= w_f2;
	end

	assign pf = (w_f3.status == ST_OK) ? p_f3 : '0;

	always_comb begin
		out_valid                  = v_f3;
		out_item.temperature_centi = w_f3.temp;
		out_item.pressure_pa       = pf;
		out_item.status            = w_f3.status;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		v_f3 && w_f3.status != ST_OK |-> out_item.pressure_pa == '0)
		else $error("error result carries pressure");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##35 out_valid)
		else $error("item lost in back end");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_work.status == ST_OK |-> in_work.den != '0)
		else $error("zero divisor marked ok");

endmodule

// ----- design/baro_temp_pressure_compensation_core.sv -----
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core: barometer compensation engine
// 32-bit integer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// channel  | signals                        | handshake
// input    | start, busy, in_item           | taken when start && !busy
// result   | done, result                   | one-cycle strobe, no stall
// config   | cfg_we, cfg_index, cfg_data    | written when cfg_we
//
// One item is taken per cycle; busy stays low, the engine never stalls.
// Path from start to done: 8 front stages, the queue, 32 divider rows
// (one quotient bit each) and 3 finish stages.
// Reset clears pipeline valids and loads the registers with their defaults.
// The receiver cannot stall, so the back end pops the queue whenever it holds
// an item and the queue never fills.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_core #(
	parameter int QueueDepth = btpc_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  btpc_pkg::in_item_t   in_item,
	output logic                 done,
	output btpc_pkg::out_item_t  result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [47:0]          cfg_data
);
	import btpc_pkg::*;

	logic [47:0] temp_calib_q, press_a_q, press_b_q, press_c_q;
	logic [2:0]  osr_q;
	logic        f_valid, q_ne;
	work_t       f_work, q_work;

	// Hold the calibration set; ignore writes beyond the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
			osr_q        <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_CALIB:   temp_calib_q <= cfg_data;
				REG_PRESS_A:      press_a_q    <= cfg_data;
				REG_PRESS_B:      press_b_q    <= cfg_data;
				REG_PRESS_C:      press_c_q    <= cfg_data;
				REG_OVERSAMPLING: osr_q        <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	btpc_front u_front (
		.clk, .arst_n,
		.in_valid   (start && !busy),
		.in_item    (in_item),
		.temp_calib (temp_calib_q),
		.press_a    (press_a_q),
		.press_b    (press_b_q),
		.osr        (osr_q),
		.out_valid  (f_valid),
		.out_work   (f_work)
	);

	btpc_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n,
		.push      (f_valid),
		.push_data (f_work),
		.pop       (q_ne),
		.not_empty (q_ne),
		.pop_data  (q_work)
	);

	btpc_back u_back (
		.clk, .arst_n,
		.in_valid  (q_ne),
		.in_work   (q_work),
		.press_c   (press_c_q),
		.out_valid (done),
		.out_item  (result)
	);

endmodule
